### hdl/mlsf_pkg.sv
// ----------------------------------------------------------------------------
// mlsf_pkg: shared types, constants and port helper functions
// Payload structs, table packet format and group / attach logic for the
// MAC learning switch forwarder.
// ----------------------------------------------------------------------------
package mlsf_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int NUM_PORTS   = 8;
  localparam int GROUP_BITS  = 3;

  localparam int MAC_W   = 48;
  localparam int PORT_W  = 3;
  localparam int GRP_W   = NUM_PORTS * GROUP_BITS;
  localparam int TBL_AW  = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int MAXE_W  = 9;
  localparam int CMP_W   = (CNT_W > MAXE_W) ? CNT_W + 1 : MAXE_W + 1;
  localparam int LFSR_W  = 16;
  localparam int MOD_CW  = $clog2(LFSR_W);
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 24;
  localparam int MCAST_BIT = 40;

  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h0001;

  localparam logic [MAXE_W-1:0]    MAXE_RST = 9'd256;
  localparam logic [NUM_PORTS-1:0] ATT_RST  = 8'hFF;
  localparam logic [GRP_W-1:0]     GRP_RST  = 24'd16434824;

  typedef enum logic [CFG_IW-1:0] {
    REG_ROUTING_MODE  = 3'd0,
    REG_RELAY_ENABLED = 3'd1,
    REG_MAX_ENTRIES   = 3'd2,
    REG_PORT_ATTACHED = 3'd3,
    REG_PORT_GROUP    = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_SEARCH = 3'd1,
    OP_INSERT = 3'd2,
    OP_EVICT  = 3'd3,
    OP_LOOKUP = 3'd4
  } op_e;

  typedef struct packed {
    logic [PORT_W-1:0] arrival_port;
    logic [MAC_W-1:0]  dest_mac;
    logic [MAC_W-1:0]  src_mac;
  } in_t;

  typedef struct packed {
    logic [NUM_PORTS-1:0] forward_mask;
    logic                 table_hit;
    logic                 stale_removed;
    logic                 evicted;
  } out_t;

  // packet travelling down the table chain
  typedef struct packed {
    op_e               op;
    logic [MAC_W-1:0]  mac;
    logic [PORT_W-1:0] port;
    logic [TBL_AW-1:0] k;
    logic              flag;
  } pkt_t;

  function automatic logic port_attached(input logic [NUM_PORTS-1:0] att,
                                         input logic [PORT_W-1:0] p);
    logic r;
    r = 1'b0;
    if (int'(p) < NUM_PORTS) r = att[int'(p)];
    return r;
  endfunction

  // ports beyond the port count get a group of their own
  function automatic logic [GROUP_BITS:0] group_of(input logic [GRP_W-1:0] grp,
                                                   input logic [PORT_W-1:0] p);
    logic [GROUP_BITS:0] g;
    g = {1'b1, {GROUP_BITS{1'b0}}};
    if (int'(p) < NUM_PORTS) g = {1'b0, grp[GROUP_BITS*int'(p) +: GROUP_BITS]};
    return g;
  endfunction

  function automatic logic may_send(input logic [PORT_W-1:0] from,
                                    input logic [PORT_W-1:0] to,
                                    input logic [NUM_PORTS-1:0] att,
                                    input logic [GRP_W-1:0] grp,
                                    input logic relay);
    logic r;
    r = 1'b0;
    if (from != to && port_attached(att, to))
      r = relay || (group_of(grp, from) != group_of(grp, to));
    return r;
  endfunction

  function automatic logic [NUM_PORTS-1:0] flood_mask(input logic [PORT_W-1:0] from,
                                                      input logic [NUM_PORTS-1:0] att,
                                                      input logic [GRP_W-1:0] grp,
                                                      input logic relay);
    logic [NUM_PORTS-1:0] m;
    for (int p = 0; p < NUM_PORTS; p++)
      m[p] = may_send(from, PORT_W'(p), att, grp, relay);
    return m;
  endfunction

endpackage

### hdl/mlsf_cell.sv
// ----------------------------------------------------------------------------
// mlsf_cell: one table entry
// Holds one MAC / port pair with its valid bit, acts on the passing packet
// and hands it on, registered, to the next cell.
// ----------------------------------------------------------------------------
module mlsf_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [mlsf_pkg::NUM_PORTS-1:0] attached_i,
  input  mlsf_pkg::pkt_t                 pkt_i,
  output mlsf_pkg::pkt_t                 pkt_o
);
  import mlsf_pkg::*;

  logic [MAC_W-1:0]  mac_q, mac_d;
  logic [PORT_W-1:0] port_q, port_d;
  logic              valid_q, valid_d;
  pkt_t              pkt_q, pkt_d;
  logic              match;

  assign match = valid_q && (mac_q == pkt_i.mac);

  always_comb begin
    mac_d   = mac_q;
    port_d  = port_q;
    valid_d = valid_q;
    pkt_d   = pkt_i;
    unique case (pkt_i.op)
      OP_SEARCH: begin
        if (match) begin
          port_d     = pkt_i.port;
          pkt_d.flag = 1'b1;
        end
      end
      OP_INSERT: begin
        // first free cell takes the new address
        if (!valid_q && !pkt_i.flag) begin
          valid_d    = 1'b1;
          mac_d      = pkt_i.mac;
          port_d     = pkt_i.port;
          pkt_d.flag = 1'b1;
        end
      end
      OP_EVICT: begin
        // k counts down over valid cells; the k-th one drops out
        if (valid_q && !pkt_i.flag) begin
          if (pkt_i.k == '0) begin
            valid_d    = 1'b0;
            pkt_d.flag = 1'b1;
          end else begin
            pkt_d.k = pkt_i.k - TBL_AW'(1);
          end
        end
      end
      OP_LOOKUP: begin
        if (match) begin
          pkt_d.flag = 1'b1;
          pkt_d.port = port_q;
          if (!port_attached(attached_i, port_q)) valid_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pkt_q   <= '0;
    end else begin
      valid_q <= valid_d;
      pkt_q   <= pkt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mac_q  <= mac_d;
    port_q <= port_d;
  end

  assign pkt_o = pkt_q;

endmodule

### hdl/mlsf_mod.sv
// ----------------------------------------------------------------------------
// mlsf_mod: iterative remainder unit
// Restoring remainder of the LFSR value by the entry count, one bit a cycle.
// ----------------------------------------------------------------------------
module mlsf_mod (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [mlsf_pkg::LFSR_W-1:0] dividend_i,
  input  logic [mlsf_pkg::CNT_W-1:0]  divisor_i,
  output logic                        done_o,
  output logic [mlsf_pkg::CNT_W-1:0]  rem_o
);
  import mlsf_pkg::*;

  logic              run_q, done_q;
  logic [MOD_CW-1:0] cnt_q;
  logic [LFSR_W-1:0] val_q;
  logic [CNT_W-1:0]  div_q, rem_q, rem_d;
  logic [CNT_W:0]    trial;

  assign trial = {rem_q, val_q[LFSR_W-1]};

  always_comb begin
    if (trial >= {1'b0, div_q}) rem_d = CNT_W'(trial - {1'b0, div_q});
    else                        rem_d = CNT_W'(trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + MOD_CW'(1);
        if (cnt_q == MOD_CW'(LFSR_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (run_q) begin
      val_q <= val_q << 1;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

### hdl/mac_learning_switch_forwarder.sv
// ----------------------------------------------------------------------------
// mac_learning_switch_forwarder: header forwarding decision with MAC learning
// Sequencer, configuration registers and the chain of table cells.
// ----------------------------------------------------------------------------
// Usage
//   Command channel: a header transaction is taken when start is high and
//   busy is low. One result per header appears on res_o for a single cycle
//   with res_valid_o; the receiver cannot stall, so it must sample it then.
//   Configuration: cfg_valid_i / cfg_ready_o with a register index and data;
//   ready is always high. Write only while busy is low.
//   Flow: hub mode or multicast gives the result the cycle after start.
//   Otherwise each table operation is one packet walking the cell chain,
//   one register per cell: search for the source, an insert on a miss,
//   then a lookup of the destination. Each eviction adds a remainder
//   computation and one more pass of the chain. A new unicast source
//   walks the chain for the search, the insert and the lookup, a known
//   source for the search and the lookup only; one item in flight at a
//   time.
//   Reset: table empty, count zero, LFSR at seed one, registers at defaults.
// ----------------------------------------------------------------------------
module mac_learning_switch_forwarder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  mlsf_pkg::in_t               in_i,
  output logic                        res_valid_o,
  output mlsf_pkg::out_t              res_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [mlsf_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [mlsf_pkg::CFG_DW-1:0] cfg_data_i
);
  import mlsf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_MOD, S_EVICT, S_INSERT, S_LIMIT, S_LOOKUP
  } state_e;

  // configuration registers
  logic                 mode_q, relay_q;
  logic [MAXE_W-1:0]    maxe_q;
  logic [NUM_PORTS-1:0] att_q;
  logic [GRP_W-1:0]     grp_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      relay_q <= 1'b0;
      maxe_q  <= MAXE_RST;
      att_q   <= ATT_RST;
      grp_q   <= GRP_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ROUTING_MODE:  mode_q  <= cfg_data_i[0];
        REG_RELAY_ENABLED: relay_q <= cfg_data_i[0];
        REG_MAX_ENTRIES:   maxe_q  <= cfg_data_i[MAXE_W-1:0];
        REG_PORT_ATTACHED: att_q   <= cfg_data_i[NUM_PORTS-1:0];
        REG_PORT_GROUP:    grp_q   <= cfg_data_i[GRP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // cell chain: chain[0] is driven by the sequencer, chain[TABLE_DEPTH] returns
  pkt_t chain [TABLE_DEPTH+1];

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    mlsf_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .attached_i (att_q),
      .pkt_i      (chain[i]),
      .pkt_o      (chain[i+1])
    );
  end

  pkt_t last;
  assign last = chain[TABLE_DEPTH];

  // sequencer
  state_e            state_q;
  logic [CNT_W-1:0]  count_q;
  logic [LFSR_W-1:0] lfsr_q, lfsr_nx;
  in_t               hdr_q;
  logic              ins_pend_q, ev_q, mod_start_q;
  pkt_t              pkt_q;
  out_t              res_q;
  logic              res_valid_q;
  logic              mod_done;
  logic [CNT_W-1:0]  mod_rem;
  logic [CMP_W-1:0]  limit;

  assign chain[0] = pkt_q;

  assign lfsr_nx = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);

  // max_entries clamped to 1..TABLE_DEPTH
  always_comb begin
    if (maxe_q == '0)                            limit = CMP_W'(1);
    else if (CMP_W'(maxe_q) > CMP_W'(TABLE_DEPTH)) limit = CMP_W'(TABLE_DEPTH);
    else                                         limit = CMP_W'(maxe_q);
  end

  mlsf_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start_q),
    .dividend_i (lfsr_q),
    .divisor_i  (count_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      lfsr_q      <= LFSR_SEED;
      ins_pend_q  <= 1'b0;
      ev_q        <= 1'b0;
      mod_start_q <= 1'b0;
      pkt_q       <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
      hdr_q       <= '0;
    end else begin
      pkt_q.op    <= OP_NONE;
      res_valid_q <= 1'b0;
      mod_start_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            hdr_q      <= in_i;
            ev_q       <= 1'b0;
            ins_pend_q <= 1'b0;
            if (mode_q || in_i.dest_mac[MCAST_BIT]) begin
              res_q <= '{flood_mask(in_i.arrival_port, att_q, grp_q, relay_q),
                         1'b0, 1'b0, 1'b0};
              res_valid_q <= 1'b1;
            end else begin
              pkt_q   <= '{OP_SEARCH, in_i.src_mac, in_i.arrival_port, '0, 1'b0};
              state_q <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (last.op != OP_NONE) begin
            if (last.flag) begin
              state_q <= S_LIMIT;
            end else if (count_q >= CNT_W'(TABLE_DEPTH)) begin
              // full table: free a slot before inserting
              ins_pend_q  <= 1'b1;
              lfsr_q      <= lfsr_nx;
              mod_start_q <= 1'b1;
              state_q     <= S_MOD;
            end else begin
              pkt_q   <= '{OP_INSERT, hdr_q.src_mac, hdr_q.arrival_port, '0, 1'b0};
              state_q <= S_INSERT;
            end
          end
        end
        S_MOD: begin
          if (mod_done) begin
            pkt_q   <= '{OP_EVICT, hdr_q.src_mac, hdr_q.arrival_port,
                         mod_rem[TBL_AW-1:0], 1'b0};
            state_q <= S_EVICT;
          end
        end
        S_EVICT: begin
          if (last.op != OP_NONE) begin
            count_q <= count_q - CNT_W'(1);
            ev_q    <= 1'b1;
            if (ins_pend_q) begin
              ins_pend_q <= 1'b0;
              pkt_q   <= '{OP_INSERT, hdr_q.src_mac, hdr_q.arrival_port, '0, 1'b0};
              state_q <= S_INSERT;
            end else begin
              state_q <= S_LIMIT;
            end
          end
        end
        S_INSERT: begin
          if (last.op != OP_NONE) begin
            count_q <= count_q + CNT_W'(1);
            state_q <= S_LIMIT;
          end
        end
        S_LIMIT: begin
          if (CMP_W'(count_q) > limit) begin
            lfsr_q      <= lfsr_nx;
            mod_start_q <= 1'b1;
            state_q     <= S_MOD;
          end else begin
            pkt_q   <= '{OP_LOOKUP, hdr_q.dest_mac, hdr_q.arrival_port, '0, 1'b0};
            state_q <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          if (last.op != OP_NONE) begin
            if (last.flag) begin
              if (!port_attached(att_q, last.port)) begin
                // stale entry already dropped by its cell
                count_q <= count_q - CNT_W'(1);
                res_q   <= '{'0, 1'b1, 1'b1, ev_q};
              end else if (may_send(hdr_q.arrival_port, last.port, att_q, grp_q,
                                    relay_q)) begin
                res_q <= '{NUM_PORTS'(1) << last.port, 1'b1, 1'b0, ev_q};
              end else begin
                res_q <= '{'0, 1'b1, 1'b0, ev_q};
              end
            end else begin
              res_q <= '{flood_mask(hdr_q.arrival_port, att_q, grp_q, relay_q),
                         1'b0, 1'b0, ev_q};
            end
            res_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### hdl/mlsf_checker.sv
// ----------------------------------------------------------------------------
// mlsf_checker: port-level checks for the forwarder
// Watches the command and result ports over time.
// ----------------------------------------------------------------------------
module mlsf_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        res_valid_o,
  input mlsf_pkg::out_t              res_o
);
  import mlsf_pkg::*;

  // a result closes the transaction
  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy)
    else $error("result shown while busy");

  // an accepted header either finishes next cycle or keeps the block busy
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || res_valid_o))
    else $error("header lost after accept");

  a_stale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.stale_removed) |->
      (res_o.table_hit && res_o.forward_mask == '0))
    else $error("stale result inconsistent");

  a_hit_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.table_hit) |-> ($countones(res_o.forward_mask) <= 1))
    else $error("table hit forwards to more than one port");

endmodule

bind mac_learning_switch_forwarder mlsf_checker u_mlsf_checker (.*);

### tb/sv/mac_learning_switch_forwarder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mac_learning_switch_forwarder_tb: self-checking bench for the forwarder
// Drives frame headers through the command port and settings through the
// register write port. A behavioural copy of the address table works out
// every decision; each result is checked against it or a typed row's value.
// ----------------------------------------------------------------------------
module mac_learning_switch_forwarder_tb;
  import mlsf_pkg::*;

  localparam int FILL_ITEMS  = 300;
  localparam int MIX_PHASES  = 6;
  localparam int MIX_ITEMS   = 92;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  in_t               in_i;
  logic              res_valid_o;
  out_t              res_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CFG_IW-1:0] cfg_index_i;
  logic [CFG_DW-1:0] cfg_data_i;

  mac_learning_switch_forwarder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Shadow copy of the settings and of the address table
  // --------------------------------------------------------------------------
  logic                 hub_mode;
  logic                 relay_on;
  logic [MAXE_W-1:0]    max_learned;
  logic [NUM_PORTS-1:0] live_ports;
  logic [GRP_W-1:0]     group_map;

  logic [MAC_W-1:0]     tbl_mac   [TABLE_DEPTH];
  logic [PORT_W-1:0]    tbl_port  [TABLE_DEPTH];
  bit                   tbl_valid [TABLE_DEPTH];
  int                   tbl_count;
  logic [LFSR_W-1:0]    victim_seq;

  out_t         pending_decisions[$];  // decisions still owed by the block
  logic [MAC_W-1:0] known_macs[$];     // recently learned sources, reused as targets
  int           errors;
  bit           may_idle;

  // --------------------------------------------------------------------------
  // Forwarding rules
  // --------------------------------------------------------------------------
  // ports past the port count sit in a group of their own
  function automatic int grp_num(logic [PORT_W-1:0] p);
    if (int'(p) >= NUM_PORTS) return 1 << GROUP_BITS;
    return int'(group_map[GROUP_BITS*int'(p) +: GROUP_BITS]);
  endfunction

  function automatic bit port_live(logic [PORT_W-1:0] p);
    return int'(p) < NUM_PORTS && live_ports[int'(p)];
  endfunction

  function automatic bit can_reach(logic [PORT_W-1:0] from, logic [PORT_W-1:0] to);
    if (from == to || !port_live(to)) return 1'b0;
    return relay_on || grp_num(from) != grp_num(to);
  endfunction

  function automatic logic [NUM_PORTS-1:0] flood_ports(logic [PORT_W-1:0] from);
    logic [NUM_PORTS-1:0] m;
    for (int p = 0; p < NUM_PORTS; p++) m[p] = can_reach(from, PORT_W'(p));
    return m;
  endfunction

  function automatic int find_entry(logic [MAC_W-1:0] mac);
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (tbl_valid[i] && tbl_mac[i] == mac) return i;
    return -1;
  endfunction

  // LFSR steps once per victim; k-th valid entry in index order goes
  function automatic void drop_victim();
    int k;
    if (tbl_count == 0) return;
    victim_seq = victim_seq[0] ? ((victim_seq >> 1) ^ LFSR_TAPS) : (victim_seq >> 1);
    k = int'(victim_seq) % tbl_count;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (tbl_valid[i]) begin
        if (k == 0) begin
          tbl_valid[i] = 1'b0;
          tbl_count--;
          return;
        end
        k--;
      end
    end
  endfunction

  function automatic out_t decide_forwarding(in_t hdr);
    out_t r;
    int   limit;
    int   s;
    int   d;
    r = '0;
    if (hub_mode || hdr.dest_mac[MCAST_BIT]) begin
      r.forward_mask = flood_ports(hdr.arrival_port);
      return r;
    end
    limit = int'(max_learned);
    if (limit < 1) limit = 1;
    if (limit > TABLE_DEPTH) limit = TABLE_DEPTH;
    // learn the source; a full table gives up one victim first
    s = find_entry(hdr.src_mac);
    if (s < 0) begin
      if (tbl_count >= TABLE_DEPTH) begin
        drop_victim();
        r.evicted = 1'b1;
      end
      for (int i = 0; i < TABLE_DEPTH; i++)
        if (s < 0 && !tbl_valid[i]) s = i;
      if (s >= 0) begin
        tbl_valid[s] = 1'b1;
        tbl_mac[s]   = hdr.src_mac;
        tbl_count++;
      end
    end
    if (s >= 0) tbl_port[s] = hdr.arrival_port;
    while (tbl_count > limit) begin
      drop_victim();
      r.evicted = 1'b1;
    end
    d = find_entry(hdr.dest_mac);
    if (d >= 0) begin
      r.table_hit = 1'b1;
      if (port_live(tbl_port[d])) begin
        if (can_reach(hdr.arrival_port, tbl_port[d]))
          r.forward_mask = NUM_PORTS'(1) << tbl_port[d];
      end else begin
        // entry points at a detached port: forget it, drop the frame
        tbl_valid[d] = 1'b0;
        tbl_count--;
        r.stale_removed = 1'b1;
      end
    end else begin
      r.forward_mask = flood_ports(hdr.arrival_port);
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, reset, time limit
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #100_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result checker: the receiver cannot stall, so every strobe is taken
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && res_valid_o) begin
      if (pending_decisions.size() == 0) begin
        report_mismatch("unexpected result", 64'(res_o), 64'd0);
      end else begin
        want = pending_decisions.pop_front();
        if (res_o.forward_mask !== want.forward_mask)
          report_mismatch("forward_mask", 64'(res_o.forward_mask), 64'(want.forward_mask));
        if (res_o.table_hit !== want.table_hit)
          report_mismatch("table_hit", 64'(res_o.table_hit), 64'(want.table_hit));
        if (res_o.stale_removed !== want.stale_removed)
          report_mismatch("stale_removed", 64'(res_o.stale_removed),
                          64'(want.stale_removed));
        if (res_o.evicted !== want.evicted)
          report_mismatch("evicted", 64'(res_o.evicted), 64'(want.evicted));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers: everything changes on the falling edge
  // --------------------------------------------------------------------------
  // random sender gap, start dropped for its length
  task automatic maybe_idle();
    if (may_idle && $urandom_range(99) < 9) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat ($urandom_range(6)) @(negedge clk_i);
    end
  endtask

  // one header transaction; start is left high for a back-to-back follower
  task automatic send_header(in_t hdr, bit typed, out_t typed_want);
    out_t predicted;
    @(negedge clk_i);
    start <= 1'b1;
    in_i  <= hdr;
    do @(posedge clk_i); while (busy);
    predicted = decide_forwarding(hdr);
    pending_decisions.push_back(typed ? typed_want : predicted);
    if (!hdr.dest_mac[MCAST_BIT] && !hub_mode) begin
      known_macs.push_back(hdr.src_mac);
      if (known_macs.size() > 48) void'(known_macs.pop_front());
    end
  endtask

  // block idle: no decision owed and nothing in flight
  task automatic wait_quiet();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_decisions.size() != 0 || busy) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_ROUTING_MODE:  hub_mode    = val[0];
      REG_RELAY_ENABLED: relay_on    = val[0];
      REG_MAX_ENTRIES:   max_learned = val[MAXE_W-1:0];
      REG_PORT_ATTACHED: live_ports  = val[NUM_PORTS-1:0];
      REG_PORT_GROUP:    group_map   = val[GRP_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Directed table: a row is either a register write or a header
  // --------------------------------------------------------------------------
  typedef struct {
    bit                is_write;
    cfg_reg_e          reg_idx;
    logic [CFG_DW-1:0] reg_val;
    in_t               hdr;
    bit                typed;
    out_t              want;
  } step_t;

  step_t directed[$];

  function automatic void row_write(cfg_reg_e idx, logic [CFG_DW-1:0] val);
    step_t r;
    r.is_write = 1'b1;
    r.reg_idx  = idx;
    r.reg_val  = val;
    r.hdr      = '0;
    r.typed    = 1'b0;
    r.want     = '0;
    directed.push_back(r);
  endfunction

  function automatic void row_hdr(logic [PORT_W-1:0] p, logic [MAC_W-1:0] dmac,
                                  logic [MAC_W-1:0] smac, bit typed,
                                  logic [NUM_PORTS-1:0] mask, bit hit, bit stale);
    step_t r;
    r.is_write         = 1'b0;
    r.reg_idx          = REG_ROUTING_MODE;
    r.reg_val          = '0;
    r.hdr.arrival_port = p;
    r.hdr.dest_mac     = dmac;
    r.hdr.src_mac      = smac;
    r.typed            = typed;
    r.want             = '{forward_mask: mask, table_hit: hit, stale_removed: stale,
                           evicted: 1'b0};
    directed.push_back(r);
  endfunction

  // test addresses, unicast apart from MAC_MCAST and MAC_BCAST
  localparam logic [MAC_W-1:0] MAC_A = 48'h0200_0000_0011;
  localparam logic [MAC_W-1:0] MAC_B = 48'h0200_0000_0022;
  localparam logic [MAC_W-1:0] MAC_C = 48'h0200_0000_0033;
  localparam logic [MAC_W-1:0] MAC_D = 48'h0200_0000_0044;
  localparam logic [MAC_W-1:0] MAC_E = 48'h0200_0000_0055;
  localparam logic [MAC_W-1:0] MAC_F = 48'h0200_0000_0066;
  localparam logic [MAC_W-1:0] MAC_G = 48'h0200_0000_0077;
  localparam logic [MAC_W-1:0] MAC_H = 48'h0200_0000_0088;
  localparam logic [MAC_W-1:0] MAC_NONE  = 48'h0200_0000_0099;
  localparam logic [MAC_W-1:0] MAC_MCAST = 48'h0100_5E00_0001;
  localparam logic [MAC_W-1:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;
  localparam logic [MAC_W-1:0] MAC_HIGH  = 48'hFEFF_FFFF_FFFF;

  function automatic void build_directed();
    // after reset every port has a group of its own
    row_hdr(3'd0, MAC_NONE, MAC_A, 1, 8'hFE, 0, 0);     // unknown target floods
    row_hdr(3'd1, MAC_A, MAC_B, 1, 8'h01, 1, 0);        // learned target
    row_hdr(3'd0, MAC_MCAST, MAC_A, 1, 8'hFE, 0, 0);    // multicast floods
    row_hdr(3'd7, MAC_BCAST, '0, 1, 8'h7F, 0, 0);       // broadcast, top port
    row_hdr(3'd3, MAC_C, MAC_C, 1, 8'h00, 1, 0);        // target is the arrival port
    row_hdr(3'd5, '0, MAC_HIGH, 1, 8'hDF, 0, 0);        // all-zero target misses
    row_hdr(3'd2, MAC_HIGH, MAC_BCAST, 1, 8'h20, 1, 0); // all-ones source learned
    // target behind a detached port: entry removed, frame dropped
    row_write(REG_PORT_ATTACHED, 24'hFE);
    row_hdr(3'd2, MAC_A, MAC_B, 1, 8'h00, 1, 1);
    row_write(REG_PORT_ATTACHED, 24'hFF);
    row_hdr(3'd4, MAC_A, MAC_D, 1, 8'hEF, 0, 0);        // gone, so floods
    // one group for all ports
    row_write(REG_PORT_GROUP, 24'h0);
    row_hdr(3'd1, MAC_NONE, MAC_B, 1, 8'h00, 0, 0);
    row_write(REG_RELAY_ENABLED, 24'h1);
    row_hdr(3'd1, MAC_NONE, MAC_B, 1, 8'hFD, 0, 0);
    row_hdr(3'd1, MAC_C, MAC_B, 1, 8'h08, 1, 0);
    row_write(REG_RELAY_ENABLED, 24'h0);
    row_write(REG_PORT_GROUP, 24'hFFFFFF);
    row_hdr(3'd6, MAC_C, MAC_E, 1, 8'h00, 1, 0);        // hit inside own group
    row_write(REG_PORT_GROUP, GRP_RST);
    row_write(REG_ROUTING_MODE, 24'h1);
    row_hdr(3'd0, MAC_C, MAC_F, 1, 8'hFE, 0, 0);        // hub floods
    row_write(REG_ROUTING_MODE, 24'h0);
    // shrinking the table evicts down to the limit
    row_write(REG_MAX_ENTRIES, 24'd1);
    row_hdr(3'd0, MAC_F, MAC_G, 0, '0, 0, 0);
    row_hdr(3'd2, MAC_G, MAC_H, 0, '0, 0, 0);
    row_write(REG_MAX_ENTRIES, 24'd0);                  // acts as one
    row_hdr(3'd3, MAC_H, MAC_A, 0, '0, 0, 0);
    row_write(REG_MAX_ENTRIES, 24'd511);                // clipped to the depth
    row_hdr(3'd4, MAC_A, MAC_B, 0, '0, 0, 0);
    row_write(REG_MAX_ENTRIES, 24'd256);
  endfunction

  // --------------------------------------------------------------------------
  // Random headers
  // --------------------------------------------------------------------------
  function automatic logic [MAC_W-1:0] rand_mac();
    return MAC_W'({$urandom(), $urandom()});
  endfunction

  function automatic in_t rand_hdr(bit fresh_src);
    in_t h;
    int  pick;
    h.arrival_port = PORT_W'($urandom_range(NUM_PORTS - 1));
    pick = $urandom_range(99);
    if (pick < 60 && known_macs.size() != 0)
      h.dest_mac = known_macs[$urandom_range(known_macs.size() - 1)];
    else if (pick < 72)
      h.dest_mac = rand_mac() | (48'h1 << MCAST_BIT);
    else
      h.dest_mac = rand_mac() & ~(48'h1 << MCAST_BIT);
    if (!fresh_src && known_macs.size() != 0 && $urandom_range(99) < 70)
      h.src_mac = known_macs[$urandom_range(known_macs.size() - 1)];
    else
      h.src_mac = rand_mac();
    return h;
  endfunction

  function automatic logic [CFG_DW-1:0] rand_limit();
    case ($urandom_range(7))
      0: return 24'd1;
      1: return 24'd0;
      2: return 24'd2;
      3: return 24'd16;
      4: return 24'd511;
      5: return 24'd256;
      default: return CFG_DW'($urandom_range(511));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    out_t none;
    none        = '0;
    errors      = 0;
    may_idle    = 1'b1;
    start       = 1'b0;
    in_i        = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    hub_mode    = 1'b0;
    relay_on    = 1'b0;
    max_learned = MAXE_RST;
    live_ports  = ATT_RST;
    group_map   = GRP_RST;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_mac[i]   = '0;
      tbl_port[i]  = '0;
    end
    tbl_count  = 0;
    victim_seq = LFSR_SEED;

    rst_ni = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    build_directed();
    foreach (directed[i]) begin
      if (directed[i].is_write) begin
        wait_quiet();
        write_reg(directed[i].reg_idx, directed[i].reg_val);
      end else begin
        send_header(directed[i].hdr, directed[i].typed, directed[i].want);
        maybe_idle();
      end
    end

    // fill phase: fresh sources run the table past full, no sender gaps
    wait_quiet();
    write_reg(REG_ROUTING_MODE, 24'h0);
    write_reg(REG_MAX_ENTRIES, 24'd256);
    write_reg(REG_PORT_ATTACHED, 24'hFF);
    may_idle = 1'b0;
    for (int n = 0; n < FILL_ITEMS; n++) send_header(rand_hdr(1'b1), 1'b0, none);
    may_idle = 1'b1;

    // mixed phases, each with its own settings
    for (int ph = 0; ph < MIX_PHASES; ph++) begin
      wait_quiet();
      write_reg(REG_ROUTING_MODE, CFG_DW'($urandom_range(99) < 20));
      write_reg(REG_RELAY_ENABLED, CFG_DW'($urandom_range(1)));
      write_reg(REG_MAX_ENTRIES, rand_limit());
      case ($urandom_range(3))
        0:       write_reg(REG_PORT_ATTACHED, 24'h00);
        1:       write_reg(REG_PORT_ATTACHED, 24'hFF);
        default: write_reg(REG_PORT_ATTACHED, CFG_DW'($urandom_range(255)));
      endcase
      case ($urandom_range(3))
        0:       write_reg(REG_PORT_GROUP, GRP_RST);
        1:       write_reg(REG_PORT_GROUP, 24'hFFFFFF);
        default: write_reg(REG_PORT_GROUP, CFG_DW'($urandom()));
      endcase
      for (int n = 0; n < MIX_ITEMS; n++) begin
        send_header(rand_hdr($urandom_range(99) < 25), 1'b0, none);
        maybe_idle();
      end
    end

    wait_quiet();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
